// ===== rtl/ibht_pkg.sv =====
// Shared types and constants for the image barrier hazard tracker.
// No dependencies.
package ibht_pkg;

  localparam int SLOT_W   = 8;
  localparam int LAYOUT_W = 5;
  localparam int MASK_W   = 64;
  localparam int ASPECT_W = 4;

  localparam int S_TDATA_W = 152;  // 145 field bits, padded to bytes
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 280;  // 278 field bits, padded to bytes

  localparam logic [LAYOUT_W-1:0] LAYOUT_UNDEFINED  = '0;
  localparam logic [MASK_W-1:0]   TOP_OF_PIPE_STAGE = MASK_W'(1);

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [LAYOUT_W-1:0] want_layout;
    logic [MASK_W-1:0]   want_access;
    logic                wr_flag;
    logic [MASK_W-1:0]   stage_mask;
    logic                discard;
    logic [ASPECT_W-1:0] aspect;
  } req_t;

  typedef struct packed {
    logic [LAYOUT_W-1:0] cur_layout;
    logic [MASK_W-1:0]   write_stages;
    logic [MASK_W-1:0]   write_access;
    logic [MASK_W-1:0]   reader_set;
    logic [MASK_W-1:0]   seen_stages;
    logic [MASK_W-1:0]   seen_access;
  } rec_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   out_slot;
    logic [ASPECT_W-1:0] out_aspect;
    logic [LAYOUT_W-1:0] prev_layout;
    logic [LAYOUT_W-1:0] post_layout;
    logic [MASK_W-1:0]   src_stages;
    logic [MASK_W-1:0]   src_acc;
    logic [MASK_W-1:0]   dst_stages;
    logic [MASK_W-1:0]   dst_acc;
  } res_t;

endpackage

// ===== rtl/image_barrier_hazard_tracker_unit.sv =====
// Image barrier hazard tracker, top level: request stage, record memory with
// write forwarding, decision logic and output register. Uses ibht_pkg, ibht_table, ibht_decide.
// A request is registered in the request stage, and its barrier word then in the output register that drives m_tvalid.
// Throughput: 1 request per cycle, one read-modify-write of the record memory per in-range request;
// a held output word stalls requests that produce a barrier.
// Reset: rst (sync, active high) empties the pipeline and marks every record cleared.
module image_barrier_hazard_tracker_unit #(
  parameter int NUM_IMAGES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // slot[7:0] want_layout[12:8] want_access[76:13] stage_mask[140:77] aspect[144:141]
  input  logic [ibht_pkg::S_TDATA_W-1:0] s_tdata,
  // wr_flag[0] discard[1]
  input  logic [ibht_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_slot[7:0] out_aspect[11:8] prev_layout[16:12] post_layout[21:17]
  // src_stages[85:22] src_acc[149:86] dst_stages[213:150] dst_acc[277:214]
  output logic [ibht_pkg::M_TDATA_W-1:0] m_tdata
);
  import ibht_pkg::*;

  localparam int DEPTH = (NUM_IMAGES < 256) ? NUM_IMAGES : 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  req_t             in_req;
  logic             accept;
  logic             s1_valid;
  req_t             s1_req;
  logic             s1_inrange;
  logic             s1_adv;
  logic             s1_emit;
  logic [IDX_W-1:0] s1_idx;
  rec_t             tbl_rec;
  rec_t             cur_rec;
  rec_t             nxt_rec;
  res_t             dec_res;
  logic             dec_emit;
  logic             tbl_we;
  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  rec_t             fwd_rec;
  logic             out_load;

  assign in_req.slot        = s_tdata[7:0];
  assign in_req.want_layout = s_tdata[12:8];
  assign in_req.want_access = s_tdata[76:13];
  assign in_req.stage_mask  = s_tdata[140:77];
  assign in_req.aspect      = s_tdata[144:141];
  assign in_req.wr_flag     = s_tuser[0];
  assign in_req.discard     = s_tuser[1];

  assign s1_idx   = s1_req.slot[IDX_W-1:0];
  assign s1_emit  = s1_inrange && dec_emit;
  assign s1_adv   = s1_valid && (!s1_emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign tbl_we   = s1_adv && s1_inrange;
  assign out_load = s1_adv && s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req     <= in_req;
      s1_inrange <= {24'd0, in_req.slot} < 32'(NUM_IMAGES);
    end
  end

  ibht_table #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (in_req.slot[IDX_W-1:0]),
    .rd_rec (tbl_rec),
    .we     (tbl_we),
    .wr_idx (s1_idx),
    .wr_rec (nxt_rec)
  );

  // last write covers a read issued in the same cycle as its write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (tbl_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      fwd_idx <= s1_idx;
      fwd_rec <= nxt_rec;
    end
  end

  assign cur_rec = (fwd_valid && fwd_idx == s1_idx) ? fwd_rec : tbl_rec;

  ibht_decide u_decide (
    .req  (s1_req),
    .cur  (cur_rec),
    .emit (dec_emit),
    .res  (dec_res),
    .nxt  (nxt_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, dec_res.dst_acc, dec_res.dst_stages, dec_res.src_acc,
                  dec_res.src_stages, dec_res.post_layout, dec_res.prev_layout,
                  dec_res.out_aspect, dec_res.out_slot};
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid)
    else $error("input stalled with empty request stage");

  a_no_write_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_inrange) |-> !tbl_we && !out_load)
    else $error("out-of-range slot touched the table or output");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (rst)
    tbl_we |=> fwd_valid && fwd_idx == $past(s1_idx))
    else $error("forward register missed a table write");

  a_load_shows_word: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("barrier word lost at output register");
`endif

endmodule

// ===== rtl/ibht_table.sv =====
// Hazard record memory: registered read, one write port,
// per-entry valid bits so unwritten entries read as the cleared record. Uses ibht_pkg.
module ibht_table #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_idx,
  output ibht_pkg::rec_t     rd_rec,
  input  logic               we,
  input  logic [IDX_W-1:0]   wr_idx,
  input  ibht_pkg::rec_t     wr_rec
);
  import ibht_pkg::*;

  rec_t             mem [DEPTH];
  logic [DEPTH-1:0] vld;
  rec_t             rd_data;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_idx];
      end
    end
  end

  assign rd_rec = rd_vld ? rd_data : '0;

endmodule

// ===== rtl/ibht_decide.sv =====
// Barrier decision and record update for one request.
// Pure combinational; uses ibht_pkg.
module ibht_decide (
  input  ibht_pkg::req_t req,
  input  ibht_pkg::rec_t cur,
  output logic           emit,
  output ibht_pkg::res_t res,
  output ibht_pkg::rec_t nxt
);
  import ibht_pkg::*;

  logic              change;
  logic              covered;
  logic [MASK_W-1:0] wr_src;

  always_comb begin
    change  = req.discard || (req.want_layout != cur.cur_layout);
    covered = ((cur.seen_stages & req.stage_mask) == req.stage_mask) &&
              ((cur.seen_access & req.want_access) == req.want_access);
    wr_src  = cur.write_stages | cur.reader_set;
    if (wr_src == '0) begin
      wr_src = TOP_OF_PIPE_STAGE;
    end

    res.out_slot   = req.slot;
    res.out_aspect = req.aspect;
    res.dst_stages = req.stage_mask;
    res.dst_acc    = req.want_access;
    res.src_acc    = cur.write_access;

    if (!req.wr_flag && !change) begin
      // read in current layout
      emit            = !covered;
      res.prev_layout = cur.cur_layout;
      res.post_layout = cur.cur_layout;
      res.src_stages  = cur.write_stages;
      nxt             = cur;
      nxt.reader_set  = cur.reader_set | req.stage_mask;
      if (!covered) begin
        nxt.seen_stages = cur.seen_stages | req.stage_mask;
        nxt.seen_access = cur.seen_access | req.want_access;
      end
    end else begin
      emit             = 1'b1;
      res.prev_layout  = req.discard ? LAYOUT_UNDEFINED : cur.cur_layout;
      res.post_layout  = req.want_layout;
      res.src_stages   = wr_src;
      nxt.cur_layout   = req.want_layout;
      nxt.write_stages = req.stage_mask;
      nxt.write_access = req.want_access;
      nxt.reader_set   = '0;
      nxt.seen_stages  = req.stage_mask;
      nxt.seen_access  = req.want_access;
    end
  end

endmodule
